// ----- hdl/puc_pkg.sv -----
// Shared types and constants of the percent codec core.
package puc_pkg;

  // Width of one string byte and of the per-string byte count.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  // One item yields at most this many data bytes.
  localparam int unsigned JobSlots = 3;
  localparam int unsigned SlotCntW = $clog2(JobSlots + 1);
  localparam int unsigned SlotIdxW = $clog2(JobSlots);

  // Depth of the queue between the front and the back end.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgEncodeMode     = 2'd0,
    CfgOutputCapacity = 2'd1
  } cfg_idx_e;

  // Current configuration as seen by the front end.
  typedef struct packed {
    logic              encode_mode;
    logic [CountW-1:0] output_capacity;
  } cfg_t;

  // Work handed from the front to the back end for one input item.
  typedef struct packed {
    logic [JobSlots-1:0][ByteW-1:0] data;
    logic [SlotCntW-1:0]            n_bytes;
    logic                           is_end;
    logic                           fits;
    logic [CountW-1:0]              count;
  } job_t;

endpackage

// ----- hdl/puc_front.sv -----
// Front end: accepts input bytes, runs the escape state and the byte count, builds jobs.
module puc_front import puc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output job_t             job_o
);

  localparam logic [ByteW-1:0] CharNul   = 8'h00;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharPct   = 8'h25;
  localparam logic [ByteW-1:0] CharPlus  = 8'h2B;
  localparam logic [ByteW-1:0] CharTilde = 8'h7E;

  // True for 0-9, a-f and A-F.
  function automatic logic hex_ok(input logic [ByteW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Value of a hex digit; letters of both cases have the value in their low bits plus nine.
  function automatic logic [3:0] hex_nib(input logic [ByteW-1:0] c);
    return (c <= 8'h39) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

  // Upper-case hex character for a nibble.
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] d);
    logic [3:0] v;
    v = d & 4'hf;
    return (v < 4'hA) ? {4'h3, v} : 8'(8'h41 + {4'h0, v} - 8'h0A);
  endfunction

  // Bytes that the encoder turns into an escape.
  function automatic logic needs_escape(input logic [ByteW-1:0] c);
    logic r;
    if (c <= CharSpace || c > CharTilde) begin
      r = 1'b1;
    end else begin
      case (c) inside
        8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h25: r = 1'b1;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Decoded form of a byte outside an escape.
  function automatic logic [ByteW-1:0] plain_byte(input logic [ByteW-1:0] c);
    return (c == CharPlus) ? CharSpace : c;
  endfunction

  logic [1:0]                     held_cnt_q, held_cnt_d;
  logic [ByteW-1:0]               held_byte_q, held_byte_d;
  logic [CountW-1:0]              written_q, written_d;
  logic                           accept;
  logic [JobSlots-1:0][ByteW-1:0] slot;
  logic [SlotCntW-1:0]            n_raw;
  logic [SlotCntW-1:0]            n_emit;
  logic                           is_end;
  logic [CountW-1:0]              rem;
  logic [CountW:0]                sum;
  logic [CountW-1:0]              wc_new;
  logic [ByteW-1:0]               c;

  assign c          = data_byte_i;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the byte and work out the bytes it produces and the next state.
  always_comb begin
    slot        = '0;
    n_raw       = '0;
    is_end      = 1'b0;
    held_cnt_d  = held_cnt_q;
    held_byte_d = held_byte_q;
    rem         = cfg_i.output_capacity - written_q;
    sum         = '0;
    if (cfg_i.encode_mode) begin
      held_cnt_d = 2'd0;
      if (c == CharNul) begin
        is_end = 1'b1;
      end else if (written_q < cfg_i.output_capacity) begin
        if (c == CharSpace) begin
          slot[0] = CharPlus;
          n_raw   = SlotCntW'(1);
        end else if (needs_escape(c)) begin
          slot[0] = CharPct;
          slot[1] = hex_char(c[7:4]);
          slot[2] = hex_char(c[3:0]);
          n_raw   = SlotCntW'(3);
        end else begin
          slot[0] = c;
          n_raw   = SlotCntW'(1);
        end
      end
      // Bytes past the capacity are dropped.
      n_emit = (rem < CountW'(n_raw)) ? SlotCntW'(rem) : n_raw;
      wc_new = written_q + CountW'(n_emit);
    end else begin
      if (c == CharNul) begin
        // End of string flushes a pending escape as plain bytes.
        is_end = 1'b1;
        if (held_cnt_q != 2'd0) begin
          slot[0] = CharPct;
          n_raw   = SlotCntW'(1);
        end
        if (held_cnt_q >= 2'd2) begin
          slot[1] = held_byte_q;
          n_raw   = SlotCntW'(2);
        end
      end else if (held_cnt_q == 2'd0) begin
        if (c == CharPct) begin
          held_cnt_d = 2'd1;
        end else begin
          slot[0] = plain_byte(c);
          n_raw   = SlotCntW'(1);
        end
      end else if (held_cnt_q == 2'd1) begin
        if (hex_ok(c)) begin
          held_byte_d = c;
          held_cnt_d  = 2'd2;
        end else begin
          slot[0] = CharPct;
          if (c == CharPct) begin
            held_cnt_d = 2'd1;
            n_raw      = SlotCntW'(1);
          end else begin
            held_cnt_d = 2'd0;
            slot[1]    = plain_byte(c);
            n_raw      = SlotCntW'(2);
          end
        end
      end else begin
        held_cnt_d = 2'd0;
        if (hex_ok(c) && hex_ok(held_byte_q)) begin
          slot[0] = {hex_nib(held_byte_q), hex_nib(c)};
          n_raw   = SlotCntW'(1);
        end else begin
          slot[0] = CharPct;
          slot[1] = held_byte_q;
          if (c == CharPct) begin
            held_cnt_d = 2'd1;
            n_raw      = SlotCntW'(2);
          end else begin
            slot[2] = plain_byte(c);
            n_raw   = SlotCntW'(3);
          end
        end
      end
      // The decoder count saturates at its top value.
      n_emit = n_raw;
      sum    = {1'b0, written_q} + (CountW + 1)'(n_raw);
      wc_new = sum[CountW] ? '1 : sum[CountW-1:0];
    end
    written_d = is_end ? '0 : wc_new;
    if (is_end) begin
      held_cnt_d  = 2'd0;
      held_byte_d = '0;
    end
  end

  // Job for the back end.
  always_comb begin
    job_o.data    = slot;
    job_o.n_bytes = n_emit;
    job_o.is_end  = is_end;
    job_o.fits    = cfg_i.encode_mode ? (wc_new < cfg_i.output_capacity) : 1'b1;
    job_o.count   = wc_new;
    push_o        = accept && (is_end || (n_emit != '0));
  end

  // String state advances on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q  <= 2'd0;
      held_byte_q <= '0;
      written_q   <= '0;
    end else if (accept) begin
      held_cnt_q  <= held_cnt_d;
      held_byte_q <= held_byte_d;
      written_q   <= written_d;
    end
  end

`ifndef SYNTH
  // An escape never holds more than the percent sign and one digit.
  a_held_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd3)
    else $error("held count out of range");
`endif

endmodule

// ----- hdl/puc_queue.sv -----
// Short register queue of jobs between the front and the back end.
module puc_queue import puc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output job_t head_o,
  output logic head_valid_o,
  output logic full_o
);

  job_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  // Storage is written at the write pointer only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : QPtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : QPtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= QCntW'(cnt_q + 1'b1);
      end else if (do_pop && !push_i) begin
        cnt_q <= QCntW'(cnt_q - 1'b1);
      end
    end
  end

`ifndef SYNTH
  // The front end never writes a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  // The fill count stays within the depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count out of range");
`endif

endmodule

// ----- hdl/puc_back.sv -----
// Back end: walks each job one result at a time into the output register.
module puc_back import puc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              end_of_string_o,
  output logic              terminator_fits_o,
  output logic [CountW-1:0] bytes_written_o
);

  logic [SlotIdxW-1:0] idx_q;
  logic                out_valid_q;
  logic [ByteW-1:0]    byte_q, byte_d;
  logic                eos_q, eos_d;
  logic                fits_q, fits_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                load;
  logic                is_last;

  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  // Pick the result at the current position of the head job.
  always_comb begin
    if (SlotCntW'(idx_q) < head_i.n_bytes) begin
      byte_d  = head_i.data[idx_q];
      eos_d   = 1'b0;
      fits_d  = 1'b0;
      count_d = '0;
    end else begin
      byte_d  = '0;
      eos_d   = 1'b1;
      fits_d  = head_i.fits;
      count_d = head_i.count;
    end
    is_last = head_i.is_end ? (SlotCntW'(idx_q) == head_i.n_bytes)
                            : (SlotCntW'(idx_q) == SlotCntW'(head_i.n_bytes - 1'b1));
    pop_o   = load && is_last;
  end

  // Position within the head job and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= is_last ? '0 : SlotIdxW'(idx_q + 1'b1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= byte_d;
      eos_q   <= eos_d;
      fits_q  <= fits_d;
      count_q <= count_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = byte_q;
  assign end_of_string_o   = eos_q;
  assign terminator_fits_o = fits_q;
  assign bytes_written_o   = count_q;

`ifndef SYNTH
  // The position never runs past the results of the head job.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (SlotCntW'(idx_q) <= head_i.n_bytes))
    else $error("job position past its results");
`endif

endmodule

// ----- hdl/percent_url_codec_core.sv -----
// Top level of the streaming percent codec: configuration registers and the three parts.
//
// Use: string bytes enter on the in channel (in_valid_i, in_ready_o, data_byte_i);
// a zero byte ends the string. Results leave on the out channel, one byte per
// transfer, and each string closes with one result that has end_of_string_o set,
// out_byte_o zero, the byte count in bytes_written_o and terminator_fits_o.
// The config channel writes encode_mode (index 0, bit 0 of the data) and
// output_capacity (index 1); it is always ready and should only be used while
// no string is in flight.
// Path: the first result of an item passes through the job queue and then the
// output register. Throughput: the input takes one byte per cycle while the queue
// is not full, and the output gives one result per cycle while results are queued
// and the receiver is ready; an item has zero to three results, which the back
// end walks out one at a time. A two-entry job queue lets the front keep accepting
// bytes while earlier results drain, until the queue is full.
// Reset clears the escape state, the count and the queue, selects decoding and
// sets the capacity to 65535. When the receiver stalls the output holds, the
// queue fills, and then in_ready_o drops until room frees up.
module percent_url_codec_core import puc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               end_of_string_o,
  output logic               terminator_fits_o,
  output logic [CountW-1:0]  bytes_written_o
);

  logic              encode_mode_q;
  logic [CountW-1:0] capacity_q;
  cfg_t              cfg;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              head_valid;
  job_t              job;
  job_t              head;

  assign cfg_ready_o         = 1'b1;
  assign cfg.encode_mode     = encode_mode_q;
  assign cfg.output_capacity = capacity_q;

  // Configuration registers, written by config transfers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encode_mode_q <= 1'b0;
      capacity_q    <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgEncodeMode:     encode_mode_q <= cfg_data_i[0];
        CfgOutputCapacity: capacity_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  puc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job)
  );

  puc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (job),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .full_o       (q_full)
  );

  puc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .head_valid_i      (head_valid),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .end_of_string_o   (end_of_string_o),
    .terminator_fits_o (terminator_fits_o),
    .bytes_written_o   (bytes_written_o)
  );

endmodule

// ----- tb/sv/puc_stream_checker.sv -----
// Checker for the percent codec core: predicts result transfers and compares them.
module puc_stream_checker import puc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [ByteW-1:0]   out_byte_i,
  input  logic               end_of_string_i,
  input  logic               terminator_fits_i,
  input  logic [CountW-1:0]  bytes_written_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam logic [ByteW-1:0] ChNul     = 8'h00;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChPlus    = 8'h2b;
  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChTilde   = 8'h7e;
  localparam logic [ByteW-1:0] ChDigit0  = 8'h30;
  localparam logic [ByteW-1:0] ChUpperA  = 8'h41;
  localparam logic [ByteW-1:0] ChLowerA  = 8'h61;
  localparam logic [CountW-1:0] CountMax = 16'hffff;
  localparam int ReportLimit = 30;

  // One result transfer as the codec should produce it.
  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic              eos;
    logic              fits;
    logic [CountW-1:0] count;
  } codec_result_t;

  codec_result_t predicted_out_q[$];

  // Shadow of the configuration and of the per-string codec state.
  logic              enc_mode   = 1'b0;
  logic [CountW-1:0] out_cap    = CountMax;
  logic [1:0]        esc_held   = 2'd0;
  logic [ByteW-1:0]  esc_digit  = 8'h00;
  logic [CountW-1:0] str_count  = '0;

  // Value of a hex digit character of either case, or -1.
  function automatic int hex_value(logic [ByteW-1:0] c);
    if (c >= ChDigit0 && c <= ChDigit0 + 8'd9) return int'(c - ChDigit0);
    if (c >= ChLowerA && c <= ChLowerA + 8'd5) return int'(c - ChLowerA) + 10;
    if (c >= ChUpperA && c <= ChUpperA + 8'd5) return int'(c - ChUpperA) + 10;
    return -1;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(logic [3:0] d);
    return (d < 4'hA) ? ChDigit0 + 8'(d) : ChUpperA + 8'(d) - 8'd10;
  endfunction

  // Bytes that the encoder turns into an escape.
  function automatic logic is_reserved(logic [ByteW-1:0] c);
    if (c <= ChSpace || c > ChTilde) return 1'b1;
    case (c)
      ":", "/", "?", "#", "[", "]", "@", "!", "$", "&", "'", "(", ")", "*",
      "+", ",", ";", "=", "%": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit_byte(logic [ByteW-1:0] b);
    codec_result_t r;
    r = '0;
    r.data = b;
    predicted_out_q.push_back(r);
    if (str_count != CountMax) str_count++;
  endtask

  task automatic emit_capped(logic [ByteW-1:0] b);
    if (str_count < out_cap) emit_byte(b);
  endtask

  // Decode a byte with no escape pending.
  task automatic decode_plain(logic [ByteW-1:0] c);
    if (c == ChPercent) esc_held = 2'd1;
    else if (c == ChPlus) emit_byte(ChSpace);
    else emit_byte(c);
  endtask

  // Work out the results of one accepted input byte.
  task automatic predict_codec_output(logic [ByteW-1:0] c);
    codec_result_t r;
    int hi;
    int lo;
    if (c == ChNul) begin
      // The terminator flushes a pending escape only when decoding.
      if (!enc_mode) begin
        if (esc_held >= 2'd1) emit_byte(ChPercent);
        if (esc_held >= 2'd2) emit_byte(esc_digit);
      end
      r = '0;
      r.eos = 1'b1;
      r.fits = enc_mode ? (str_count < out_cap) : 1'b1;
      r.count = str_count;
      predicted_out_q.push_back(r);
      esc_held = 2'd0;
      esc_digit = 8'h00;
      str_count = '0;
    end else if (enc_mode) begin
      esc_held = 2'd0;
      if (str_count < out_cap) begin
        if (c == ChSpace) begin
          emit_capped(ChPlus);
        end else if (is_reserved(c)) begin
          emit_capped(ChPercent);
          emit_capped(hex_char(c[7:4]));
          emit_capped(hex_char(c[3:0]));
        end else begin
          emit_capped(c);
        end
      end
    end else begin
      case (esc_held)
        2'd0: decode_plain(c);
        2'd1: begin
          if (hex_value(c) >= 0) begin
            esc_digit = c;
            esc_held = 2'd2;
          end else begin
            esc_held = 2'd0;
            emit_byte(ChPercent);
            decode_plain(c);
          end
        end
        default: begin
          hi = hex_value(esc_digit);
          lo = hex_value(c);
          esc_held = 2'd0;
          if (hi >= 0 && lo >= 0) begin
            emit_byte({hi[3:0], lo[3:0]});
          end else begin
            emit_byte(ChPercent);
            emit_byte(esc_digit);
            decode_plain(c);
          end
        end
      endcase
    end
  endtask

  task automatic report_mismatch(string what, int expected_val, int got_val);
    if (fail_count_o < ReportLimit) begin
      $display("ERROR: %s: expected 0x%0h, got 0x%0h at result %0d",
               what, expected_val, got_val, checked_o);
    end
    fail_count_o++;
  endtask

  // Compare each result transfer with the oldest prediction.
  task automatic check_result();
    codec_result_t exp_r;
    if (predicted_out_q.size() == 0) begin
      report_mismatch("result transfer with nothing predicted", 0, int'(out_byte_i));
    end else begin
      exp_r = predicted_out_q.pop_front();
      if (out_byte_i !== exp_r.data)
        report_mismatch("out_byte", int'(exp_r.data), int'(out_byte_i));
      if (end_of_string_i !== exp_r.eos)
        report_mismatch("end_of_string", int'(exp_r.eos), int'(end_of_string_i));
      if (terminator_fits_i !== exp_r.fits)
        report_mismatch("terminator_fits", int'(exp_r.fits), int'(terminator_fits_i));
      if (bytes_written_i !== exp_r.count)
        report_mismatch("bytes_written", int'(exp_r.count), int'(bytes_written_i));
    end
    checked_o++;
  endtask

  // Sample all three channels at the rising edge; an input transfer uses the
  // configuration from before a register write at the same edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      enc_mode = 1'b0;
      out_cap = CountMax;
      esc_held = 2'd0;
      esc_digit = 8'h00;
      str_count = '0;
      predicted_out_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_codec_output(data_byte_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgEncodeMode:     enc_mode = cfg_data_i[0];
          CfgOutputCapacity: out_cap = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = predicted_out_q.size();
  end

endmodule

// ----- tb/sv/tb_percent_url_codec_core.sv -----
// Testbench top for the percent codec core: stimulus, handshake pacing and verdict.
module tb_percent_url_codec_core;
  import puc_pkg::*;

  localparam logic [ByteW-1:0]  StrEnd    = 8'h00;
  localparam logic [ByteW-1:0]  ChSpace   = 8'h20;
  localparam logic [ByteW-1:0]  ChPlus    = 8'h2b;
  localparam logic [ByteW-1:0]  ChPercent = 8'h25;
  localparam logic [ByteW-1:0]  ChDigit0  = 8'h30;
  localparam logic [ByteW-1:0]  ChUpperA  = 8'h41;
  localparam logic [ByteW-1:0]  ChLowerA  = 8'h61;
  localparam logic [CountW-1:0] CountMax  = 16'hffff;
  localparam int RandomItems = 500;
  localparam int SettleCycles = 8;
  localparam int StallLimit = 3000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgEncodeMode;
  logic [CountW-1:0]  cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic [ByteW-1:0]   data_byte_i = StrEnd;
  logic               out_ready_i = 1'b0;
  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [ByteW-1:0]   out_byte_o;
  logic               end_of_string_o;
  logic               terminator_fits_o;
  logic [CountW-1:0]  bytes_written_o;

  int fail_count;
  int pending;
  int checked;

  // Sender pacing and run statistics.
  int burst_left = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int settings_used = 0;
  string reserved_set = ":/?#[]@!$&'()*+,;=%";

  // Receiver stall pattern.
  int stall_mode = 0;
  int stall_left = 0;

  always #1 clk_i = ~clk_i;

  percent_url_codec_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .end_of_string_o   (end_of_string_o),
    .terminator_fits_o (terminator_fits_o),
    .bytes_written_o   (bytes_written_o)
  );

  puc_stream_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_i        (out_byte_o),
    .end_of_string_i   (end_of_string_o),
    .terminator_fits_i (terminator_fits_o),
    .bytes_written_i   (bytes_written_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked)
  );

  // The receiver switches between always ready, coin-flip ready and long stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Send one byte: bursts of random length separated by random gaps.
  task automatic send_byte(logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 2);
        2: gap = $urandom_range(1, 6);
        default: gap = $urandom_range(3, 20);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    bytes_sent++;
    if (b == StrEnd) strings_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Wait until every predicted result has left, plus room for silent items.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_transfer(cfg_idx_e idx, logic [CountW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write both registers while the core is idle.
  task automatic set_config(logic mode, logic [CountW-1:0] cap);
    wait_idle();
    cfg_transfer(CfgEncodeMode, {{(CountW-1){1'b0}}, mode});
    cfg_transfer(CfgOutputCapacity, cap);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [ByteW-1:0] rand_nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [ByteW-1:0] rand_hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return ChDigit0 + 8'(d);
    return ($urandom_range(0, 1) ? ChUpperA : ChLowerA) + 8'(d - 10);
  endfunction

  // Well-formed escapes, plus signs and plain bytes, with broken and cut-off escapes mixed in.
  task automatic send_decode_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte(ChPercent);
      send_byte(rand_hex_char());
      send_byte(rand_hex_char());
    end else if (pick < 45) begin
      send_byte(ChPlus);
    end else if (pick < 55) begin
      send_byte(ChPercent);
      send_byte(rand_hex_char());
      send_byte(rand_nonzero());
    end else if (pick < 62) begin
      send_byte(ChPercent);
      send_byte(rand_nonzero());
    end else if (pick < 80) begin
      send_byte(8'($urandom_range(8'h21, 8'h7e)));
    end else begin
      send_byte(rand_nonzero());
    end
  endtask

  task automatic send_encode_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) send_byte(ChSpace);
    else if (pick < 45) send_byte(reserved_set[$urandom_range(0, reserved_set.len() - 1)]);
    else if (pick < 65) send_byte(8'($urandom_range(8'h21, 8'h7e)));
    else send_byte(rand_nonzero());
  endtask

  // Main stimulus and verdict.
  initial begin
    int random_start;
    int n_str;
    int n_tok;
    logic mode;
    logic [CountW-1:0] cap;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Decoding: plus, valid escapes, a bad digit, doubled percent, cut-off.
    set_config(1'b0, CountMax);
    send_byte(8'hff);
    send_text("+%4a%Fz%%41%");
    send_byte(StrEnd);
    send_text("%A");
    send_byte(StrEnd);

    // Switch to encoding with an escape pending, then hit the capacity mid-escape.
    send_text("%4");
    set_config(1'b1, 16'd5);
    send_text(" :/~z");
    send_byte(StrEnd);

    // Zero capacity, then the full capacity with the byte extremes and an empty string.
    set_config(1'b1, 16'd0);
    send_text("a");
    send_byte(StrEnd);
    set_config(1'b1, CountMax);
    send_byte(8'h01);
    send_byte(8'h7f);
    send_byte(8'hff);
    send_text("~A'");
    send_byte(StrEnd);
    send_byte(StrEnd);

    // Random phases; some end without a terminator so the next setting applies mid-string.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomItems) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: cap = '0;
        1: cap = CountMax;
        2: cap = CountW'($urandom_range(1, 8));
        3: cap = CountW'($urandom_range(9, 40));
        default: cap = CountW'($urandom_range(0, 65535));
      endcase
      set_config(mode, cap);
      n_str = $urandom_range(2, 5);
      for (int s = 0; s < n_str; s++) begin
        n_tok = $urandom_range(0, 10);
        repeat (n_tok) begin
          if (mode) send_encode_token();
          else send_decode_token();
        end
        if (s != n_str - 1 || $urandom_range(0, 5) != 0) send_byte(StrEnd);
      end
    end

    wait_idle();
    repeat (SettleCycles) @(negedge clk_i);
    $display("Covered %0d strings, %0d input bytes and %0d register settings.",
             strings_sent, bytes_sent, settings_used);
    $display("Checked %0d result transfers under random receiver stalls.", checked);
    if (fail_count == 0) begin
      $display("percent_url_codec_core: match");
    end else begin
      $display("percent_url_codec_core: mismatch");
    end
    $finish;
  end

  // End the run if no channel moves a transfer for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Timeout: no transfer for %0d cycles, %0d results still predicted.",
             StallLimit, pending);
    $display("percent_url_codec_core: mismatch");
    $finish;
  end

endmodule
